FILE: hdl/fplrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fplrb_pkg;

    // Default exponent width in bits.
    localparam int unsigned EXP_BITS_DEF = 20;

    // Binary64 layout.
    localparam int unsigned F_W     = 64;
    localparam int unsigned MANT_W  = 53;
    localparam int unsigned PROD_W  = 106;
    localparam int unsigned EXPO_W  = 13;
    localparam int unsigned HALF_LO = 26;
    localparam int unsigned HALF_HI = 27;

    // Fixed bit patterns.
    localparam logic [63:0] C_ONE     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] C_DEF_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0] C_EXP_MAX = 11'h7FF;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SETUP,
        S_PP,
        S_NORM,
        S_ROUND,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/float_power_left_to_right_binary.sv
`timescale 1ns / 1ps
`default_nettype none
// A scan step issues each multiply, which then runs setup, four 27x27 partial products on the
// shared multiplier plus an accumulate, a normalize pass and round. Zero, infinity and NaN
// operands skip the multiplier. Subnormal operands or results add left or right normalize
// passes. One word is worked at a time. Reset (synchronous, active low) idles and drops the
// output.
module float_power_left_to_right_binary #(
    parameter int unsigned EXP_BITS = fplrb_pkg::EXP_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [63:0]         i_base_bits,
    input  wire logic [EXP_BITS-1:0] i_exponent,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [63:0]              o_power_bits
);

    localparam int unsigned IDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(EXP_BITS - 1);

    fplrb_pkg::t_state r_state, n_state;

    logic [63:0]             r_acc;
    logic [63:0]             r_base;
    logic [EXP_BITS-1:0]     r_exp;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_bits_done;
    logic                    r_started;
    logic                    r_pend_b;
    logic [63:0]             r_a;
    logic [63:0]             r_b;
    logic [2:0]              r_pp_cnt;
    logic [fplrb_pkg::PROD_W-1:0] r_part;
    logic [fplrb_pkg::PROD_W-1:0] r_sum;
    logic                    r_stk;
    logic                    r_sign;
    logic signed [fplrb_pkg::EXPO_W-1:0] r_e;
    logic                    r_ovalid;
    logic [63:0]             r_out;

    // Operand unpacking.
    logic [10:0] a_ef, b_ef;
    logic [51:0] a_fr, b_fr;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [52:0] a_m, b_m;
    logic [10:0] a_eeff, b_eeff;

    always_comb begin
        a_ef   = r_a[62:52];
        b_ef   = r_b[62:52];
        a_fr   = r_a[51:0];
        b_fr   = r_b[51:0];
        a_nan  = (a_ef == fplrb_pkg::C_EXP_MAX) && (a_fr != '0);
        b_nan  = (b_ef == fplrb_pkg::C_EXP_MAX) && (b_fr != '0);
        a_inf  = (a_ef == fplrb_pkg::C_EXP_MAX) && (a_fr == '0);
        b_inf  = (b_ef == fplrb_pkg::C_EXP_MAX) && (b_fr == '0);
        a_zero = (a_ef == '0) && (a_fr == '0);
        b_zero = (b_ef == '0) && (b_fr == '0);
        a_m    = {(a_ef != '0), a_fr};
        b_m    = {(b_ef != '0), b_fr};
        a_eeff = (a_ef == '0) ? 11'd1 : a_ef;
        b_eeff = (b_ef == '0) ? 11'd1 : b_ef;
    end

    // Special operands bypass the multiplier.
    logic        spec_hit;
    logic [63:0] spec_res;
    logic        p_sign;

    always_comb begin
        p_sign   = r_a[63] ^ r_b[63];
        spec_hit = 1'b1;
        priority if (a_nan) begin
            spec_res = r_a | 64'h0008_0000_0000_0000;
        end else if (b_nan) begin
            spec_res = r_b | 64'h0008_0000_0000_0000;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            spec_res = fplrb_pkg::C_DEF_NAN;
        end else if (a_inf || b_inf) begin
            spec_res = {p_sign, fplrb_pkg::C_EXP_MAX, 52'd0};
        end else if (a_zero || b_zero) begin
            spec_res = {p_sign, 63'd0};
        end else begin
            spec_hit = 1'b0;
            spec_res = '0;
        end
    end

    // Shared 27x27 multiplier: one partial product per cycle.
    logic [26:0] mul_x, mul_y;
    logic [53:0] mul_p;
    logic [fplrb_pkg::PROD_W-1:0] part_sh;

    always_comb begin
        unique case (r_pp_cnt)
            3'd0: begin
                mul_x = {1'b0, a_m[25:0]};
                mul_y = {1'b0, b_m[25:0]};
            end
            3'd1: begin
                mul_x = {1'b0, a_m[25:0]};
                mul_y = b_m[52:26];
            end
            3'd2: begin
                mul_x = a_m[52:26];
                mul_y = {1'b0, b_m[25:0]};
            end
            3'd3: begin
                mul_x = a_m[52:26];
                mul_y = b_m[52:26];
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_p = {27'd0, mul_x} * {27'd0, mul_y};
        unique case (r_pp_cnt)
            3'd0:         part_sh = {52'd0, mul_p};
            3'd1, 3'd2:   part_sh = {26'd0, mul_p, 26'd0};
            3'd3:         part_sh = {mul_p[53:0], 52'd0};
            default:      part_sh = '0;
        endcase
    end

    // Normalization step: up to 16 places right for tiny results, up to 8 places left.
    logic                    need_r, need_l;
    logic signed [fplrb_pkg::EXPO_W-1:0] diff_r, emax_l;
    logic [4:0]              amt_r;
    logic [3:0]              lz8, amt_l;
    logic                    lz_found;
    logic [fplrb_pkg::PROD_W-1:0] sh_r, sh_l, lost_mask;
    logic                    lost;

    always_comb begin
        diff_r = fplrb_pkg::EXPO_W'(1) - r_e;
        emax_l = r_e - fplrb_pkg::EXPO_W'(1);
        need_r = (r_e < 1);
        need_l = !need_r && !r_sum[105] && (r_e > 1);
        amt_r  = (diff_r > 16) ? 5'd16 : diff_r[4:0];
        lz8      = 4'd8;
        lz_found = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!lz_found && r_sum[105-k]) begin
                lz8      = 4'(k);
                lz_found = 1'b1;
            end
        end
        amt_l     = (emax_l < fplrb_pkg::EXPO_W'(lz8)) ? emax_l[3:0] : lz8;
        sh_r      = r_sum >> amt_r;
        lost_mask = ~({fplrb_pkg::PROD_W{1'b1}} << amt_r);
        lost      = |(r_sum & lost_mask);
        sh_l      = r_sum << amt_l;
    end

    // Round to nearest even, carry runs into the exponent field.
    logic [52:0] rnd_m;
    logic        rnd_g, rnd_s, rnd_up;
    logic [10:0] rnd_ef;
    logic [62:0] rnd_mag;
    logic [63:0] rnd_res;

    always_comb begin
        rnd_m   = r_sum[105:53];
        rnd_g   = r_sum[52];
        rnd_s   = (|r_sum[51:0]) | r_stk;
        rnd_up  = rnd_g && (rnd_s || rnd_m[0]);
        rnd_ef  = r_sum[105] ? r_e[10:0] : 11'd0;
        rnd_mag = {rnd_ef, rnd_m[51:0]} + {62'd0, rnd_up};
        if (r_e > 2046) begin
            rnd_res = {r_sign, fplrb_pkg::C_EXP_MAX, 52'd0};
        end else begin
            rnd_res = {r_sign, rnd_mag};
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fplrb_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = fplrb_pkg::S_SCAN;
                end
            end
            fplrb_pkg::S_SCAN: begin
                priority if (r_pend_b) begin
                    n_state = fplrb_pkg::S_SETUP;
                end else if (r_bits_done) begin
                    n_state = fplrb_pkg::S_OUT;
                end else if (r_started || r_exp[r_idx]) begin
                    n_state = fplrb_pkg::S_SETUP;
                end
            end
            fplrb_pkg::S_SETUP: begin
                n_state = spec_hit ? fplrb_pkg::S_SCAN : fplrb_pkg::S_PP;
            end
            fplrb_pkg::S_PP: begin
                if (r_pp_cnt == 3'd4) begin
                    n_state = fplrb_pkg::S_NORM;
                end
            end
            fplrb_pkg::S_NORM: begin
                if (!need_r && !need_l) begin
                    n_state = fplrb_pkg::S_ROUND;
                end
            end
            fplrb_pkg::S_ROUND: begin
                n_state = fplrb_pkg::S_SCAN;
            end
            fplrb_pkg::S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_state = fplrb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fplrb_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready      = (r_state == fplrb_pkg::S_IDLE);
        o_valid      = r_ovalid;
        o_power_bits = r_out;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fplrb_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == fplrb_pkg::S_OUT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fplrb_pkg::S_IDLE: begin
                r_acc       <= fplrb_pkg::C_ONE;
                r_base      <= i_base_bits;
                r_exp       <= i_exponent;
                r_idx       <= IDX_TOP;
                r_bits_done <= 1'b0;
                r_started   <= 1'b0;
                r_pend_b    <= 1'b0;
            end
            fplrb_pkg::S_SCAN: begin
                if (r_pend_b) begin
                    r_a      <= r_acc;
                    r_b      <= r_base;
                    r_pend_b <= 1'b0;
                end else if (!r_bits_done) begin
                    if (r_started) begin
                        r_a      <= r_acc;
                        r_b      <= r_acc;
                        r_pend_b <= r_exp[r_idx];
                    end else if (r_exp[r_idx]) begin
                        r_a       <= r_acc;
                        r_b       <= r_base;
                        r_started <= 1'b1;
                    end
                    if (r_idx == '0) begin
                        r_bits_done <= 1'b1;
                    end else begin
                        r_idx <= r_idx - IDX_W'(1);
                    end
                end
            end
            fplrb_pkg::S_SETUP: begin
                r_pp_cnt <= 3'd0;
                r_sum    <= '0;
                r_stk    <= 1'b0;
                r_sign   <= p_sign;
                r_e      <= $signed({2'b00, a_eeff}) + $signed({2'b00, b_eeff})
                            - fplrb_pkg::EXPO_W'(1022);
                if (spec_hit) begin
                    r_acc <= spec_res;
                end
            end
            fplrb_pkg::S_PP: begin
                r_part   <= part_sh;
                r_pp_cnt <= r_pp_cnt + 3'd1;
                if (r_pp_cnt != 3'd0) begin
                    r_sum <= r_sum + r_part;
                end
            end
            fplrb_pkg::S_NORM: begin
                if (need_r) begin
                    r_sum <= sh_r;
                    r_stk <= r_stk | lost;
                    r_e   <= r_e + fplrb_pkg::EXPO_W'(amt_r);
                end else if (need_l) begin
                    r_sum <= sh_l;
                    r_e   <= r_e - fplrb_pkg::EXPO_W'(amt_l);
                end
            end
            fplrb_pkg::S_ROUND: begin
                r_acc <= rnd_res;
            end
            fplrb_pkg::S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    r_out <= r_acc;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // A fresh word always starts from an accumulator of one.
    a_start_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == fplrb_pkg::S_SCAN && r_acc == fplrb_pkg::C_ONE))
        else $error("accumulator not one at start of word");

    // Normalization never leaves an exponent below the subnormal floor.
    a_round_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fplrb_pkg::S_ROUND) |-> (r_e >= 1))
        else $error("rounding entered with exponent below one");

    // A normal in-range result has its leading bit in place before rounding.
    a_round_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fplrb_pkg::S_ROUND && r_e > 1 && r_e < 2047) |-> r_sum[105])
        else $error("product not normalized before rounding");

endmodule

`default_nettype wire
